FILE: hdl/tsvp_pkg.sv
`default_nettype none
package tsvp_pkg;

  // Characters with a special meaning in table text
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;

  // Depth of the event queue, and the widths of its pointers and fill count
  localparam int EvqDepth = 4;
  localparam int EvqPtrW  = $clog2(EvqDepth);
  localparam int EvqCntW  = $clog2(EvqDepth + 1);

  typedef enum logic [1:0] {
    MODE_PLAIN  = 2'd0,
    MODE_QUOTED = 2'd1,
    MODE_QSEEN  = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    EV_CHAR   = 3'd0,
    EV_FIELD  = 3'd1,
    EV_ROW    = 3'd2,
    EV_DONE   = 3'd3,
    EV_UNTERM = 3'd4
  } ev_kind_t;

  typedef struct packed {
    ev_kind_t    kind;
    logic [7:0]  char_value;
    logic        last;
  } event_t;

  // Events produced by one parse step, in order
  typedef struct packed {
    logic [1:0] count;
    event_t     ev0;
    event_t     ev1;
  } push_t;

endpackage
`default_nettype wire

FILE: hdl/tsvp_text_if.sv
`default_nettype none
interface tsvp_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink (input valid, input text_byte, input end_of_text, output ready);
endinterface
`default_nettype wire

FILE: hdl/tsvp_event_if.sv
`default_nettype none
interface tsvp_event_if;
  logic       valid;
  logic       ready;
  logic [2:0] event_kind;
  logic [7:0] char_value;
  logic       last_of_run;

  modport source (output valid, output event_kind, output char_value, output last_of_run,
                  input ready);
  modport sink (input valid, input event_kind, input char_value, input last_of_run,
                output ready);
endinterface
`default_nettype wire

FILE: hdl/tsvp_core.sv
`default_nettype none
module tsvp_core
  import tsvp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       step,
  input  wire logic [7:0] text_byte,
  input  wire logic       end_of_text,
  output push_t           push
);

  mode_t quote_mode, quote_mode_next;
  logic  field_has_chars, field_has_chars_next;
  logic  row_pending, row_pending_next;
  logic  skip_line_feed, skip_line_feed_next;

  // Decode one item against the held quoting state
  always_comb begin
    logic run_plain;
    logic is_quote;
    logic [1:0] n;
    event_t e0;
    event_t e1;
    run_plain            = 1'b0;
    is_quote             = (text_byte == CH_QUOTE);
    n                    = 2'd0;
    e0                   = '{kind: EV_CHAR, char_value: 8'd0, last: 1'b0};
    e1                   = '{kind: EV_DONE, char_value: 8'd0, last: 1'b0};
    quote_mode_next      = quote_mode;
    field_has_chars_next = field_has_chars;
    row_pending_next     = row_pending;
    skip_line_feed_next  = skip_line_feed;

    if (end_of_text) begin
      if (quote_mode == MODE_QUOTED) begin
        e0.kind = EV_UNTERM;
        n       = 2'd1;
      end else if (row_pending || field_has_chars || quote_mode == MODE_QSEEN) begin
        e0.kind = EV_ROW;
        e1.kind = EV_DONE;
        n       = 2'd2;
      end else begin
        e0.kind = EV_DONE;
        n       = 2'd1;
      end
      quote_mode_next      = MODE_PLAIN;
      field_has_chars_next = 1'b0;
      row_pending_next     = 1'b0;
      skip_line_feed_next  = 1'b0;
    end else begin
      case (quote_mode)
        MODE_QUOTED: begin
          skip_line_feed_next = 1'b0;
          if (is_quote) begin
            quote_mode_next = MODE_QSEEN;
          end else begin
            e0                   = '{kind: EV_CHAR, char_value: text_byte, last: 1'b0};
            n                    = 2'd1;
            field_has_chars_next = 1'b1;
          end
        end
        MODE_QSEEN: begin
          skip_line_feed_next = 1'b0;
          if (is_quote) begin
            // doubled quote stands for one quote character
            e0                   = '{kind: EV_CHAR, char_value: text_byte, last: 1'b0};
            n                    = 2'd1;
            field_has_chars_next = 1'b1;
            quote_mode_next      = MODE_QUOTED;
          end else begin
            // closing quote: treat this byte as unquoted text
            quote_mode_next  = MODE_PLAIN;
            row_pending_next = 1'b1;
            run_plain        = 1'b1;
          end
        end
        default: begin
          quote_mode_next     = MODE_PLAIN;
          skip_line_feed_next = 1'b0;
          // drop the LF of a CRLF pair
          if (!(skip_line_feed && text_byte == CH_LF)) begin
            run_plain = 1'b1;
          end
        end
      endcase

      if (run_plain) begin
        if (is_quote && !field_has_chars) begin
          quote_mode_next = MODE_QUOTED;
        end else if (text_byte == CH_TAB) begin
          e0.kind              = EV_FIELD;
          n                    = 2'd1;
          field_has_chars_next = 1'b0;
          row_pending_next     = 1'b1;
        end else if (text_byte == CH_CR || text_byte == CH_LF) begin
          e0.kind              = EV_ROW;
          n                    = 2'd1;
          field_has_chars_next = 1'b0;
          row_pending_next     = 1'b0;
          skip_line_feed_next  = (text_byte == CH_CR);
        end else begin
          e0                   = '{kind: EV_CHAR, char_value: text_byte, last: 1'b0};
          n                    = 2'd1;
          field_has_chars_next = 1'b1;
          row_pending_next     = 1'b1;
        end
      end
    end

    // Mark the final event of this item
    e0.last = (n == 2'd1);
    e1.last = (n == 2'd2);

    push.count = step ? n : 2'd0;
    push.ev0   = e0;
    push.ev1   = e1;
  end

  // Advance the parse state on each step
  always_ff @(posedge clk) begin
    if (rst) begin
      quote_mode      <= MODE_PLAIN;
      field_has_chars <= 1'b0;
      row_pending     <= 1'b0;
      skip_line_feed  <= 1'b0;
    end else if (step) begin
      quote_mode      <= quote_mode_next;
      field_has_chars <= field_has_chars_next;
      row_pending     <= row_pending_next;
      skip_line_feed  <= skip_line_feed_next;
    end
  end

  a_eot_clears: assert property (@(posedge clk) disable iff (rst)
    step && end_of_text |=> quote_mode == MODE_PLAIN && !field_has_chars
                            && !row_pending && !skip_line_feed)
    else $error("state not cleared after end of text");

  a_two_only_at_eot: assert property (@(posedge clk) disable iff (rst)
    push.count == 2'd2 |-> end_of_text)
    else $error("two events from a text byte");

  a_no_push_idle: assert property (@(posedge clk) disable iff (rst)
    !step |-> push.count == 2'd0)
    else $error("events pushed without a step");

endmodule
`default_nettype wire

FILE: hdl/tsvp_event_queue.sv
`default_nettype none
module tsvp_event_queue
  import tsvp_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire push_t    push,
  output logic          room,
  tsvp_event_if.source  events
);

  event_t               mem [EvqDepth];
  logic [EvqPtrW-1:0]   wr_ptr;
  logic [EvqPtrW-1:0]   rd_ptr;
  logic [EvqCntW-1:0]   count;
  logic                 pop;

  // Room for the largest burst one item can cause
  assign room = (count <= EvqCntW'(EvqDepth - 2));
  assign pop  = events.valid && events.ready;

  assign events.valid       = (count != '0);
  assign events.event_kind  = mem[rd_ptr].kind;
  assign events.char_value  = mem[rd_ptr].char_value;
  assign events.last_of_run = mem[rd_ptr].last;

  // Store pushed events in order
  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wr_ptr] <= push.ev0;
    end
    if (push.count == 2'd2) begin
      mem[wr_ptr + EvqPtrW'(1)] <= push.ev1;
    end
  end

  // Track pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + EvqPtrW'(push.count);
      rd_ptr <= rd_ptr + EvqPtrW'(pop);
      count  <= count + EvqCntW'(push.count) - EvqCntW'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= EvqCntW'(EvqDepth))
    else $error("event queue overflow");

  a_push_needs_room: assert property (@(posedge clk) disable iff (rst)
    push.count != 2'd0 |-> room)
    else $error("push without room");

  a_hold_while_stalled: assert property (@(posedge clk) disable iff (rst)
    events.valid && !events.ready |=> events.valid && $stable(events.event_kind)
                                      && $stable(events.char_value)
                                      && $stable(events.last_of_run))
    else $error("offered event changed while stalled");

endmodule
`default_nettype wire

FILE: hdl/tsv_quoted_field_parser.sv
// An accepted item is held in an input register and decoded once the event queue has
// room; its events are written into the event queue and offered on the output from it.
// Throughput: one item per cycle while the queue has room; an end-of-text item that
// closes a row gives two events, which leave the output in order from a four-entry queue.
// Reset (rst, synchronous, active high) empties the input register and event queue
// and returns the quoting state to unquoted with no field or row pending.
`default_nettype none
module tsv_quoted_field_parser
  import tsvp_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  tsvp_text_if.sink     text,
  tsvp_event_if.source  events
);

  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_eot;
  logic       room;
  logic       step;
  push_t      push;

  // Decode the held item once the queue can take its events
  assign step       = s1_valid && room;
  assign text.ready = !s1_valid || step;

  // Hold the accepted item until it is decoded
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (text.ready) begin
      s1_valid <= text.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (text.valid && text.ready) begin
      s1_byte <= text.text_byte;
      s1_eot  <= text.end_of_text;
    end
  end

  tsvp_core u_core (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .text_byte   (s1_byte),
    .end_of_text (s1_eot),
    .push        (push)
  );

  tsvp_event_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .room   (room),
    .events (events)
  );

endmodule
`default_nettype wire
